// ----- rtl/core/stbs_pkg.sv -----
`timescale 1ns / 1ps

package stbs_pkg;

    // Fixed field widths of the channel payloads
    localparam int POS_W  = 10;
    localparam int HIGH_W = 11;
    localparam int WORD_W = 32;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SEARCH = 1'b1;

    typedef struct packed {
        logic                     cmd;
        logic [POS_W-1:0]         entry_index;
        logic signed [WORD_W-1:0] entry_value;
        logic signed [WORD_W-1:0] search_key;
        logic [POS_W-1:0]         range_low;
        logic [HIGH_W-1:0]        range_high;
    } stbs_req_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } stbs_rsp_t;

endpackage

// ----- rtl/core/stbs_if.sv -----
`timescale 1ns / 1ps

interface stbs_req_if;
    import stbs_pkg::*;

    logic      valid;
    logic      ready;
    stbs_req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface stbs_rsp_if;
    import stbs_pkg::*;

    logic      valid;
    logic      ready;
    stbs_rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/core/stbs_table.sv -----
`timescale 1ns / 1ps

module stbs_table #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic signed [WIDTH-1:0]  wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic signed [WIDTH-1:0]  rdata
);

    logic signed [WIDTH-1:0] mem [DEPTH];
    logic signed [WIDTH-1:0] rdata_reg;

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/stbs_seq.sv -----
`timescale 1ns / 1ps

module stbs_seq #(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    stbs_req_if.sink                       req,
    stbs_rsp_if.source                     rsp,
    output logic                           table_we,
    output logic [$clog2(TABLE_DEPTH)-1:0] table_waddr,
    output logic signed [VALUE_WIDTH-1:0]  table_wdata,
    output logic [$clog2(TABLE_DEPTH)-1:0] table_raddr,
    input  logic signed [VALUE_WIDTH-1:0]  table_rdata
);
    import stbs_pkg::*;

    localparam int          AW      = $clog2(TABLE_DEPTH);
    localparam logic [16:0] DEPTH_L = 17'(TABLE_DEPTH);

    typedef enum logic {ST_IDLE, ST_PROBE} state_t;

    state_t                  state_reg;
    logic [POS_W-1:0]        lo_reg;
    logic [HIGH_W-1:0]       hi_reg;
    logic [POS_W-1:0]        mid_reg;
    logic signed [VALUE_WIDTH-1:0] key_reg;
    logic                    bad_reg;
    logic                    out_valid_reg;
    logic                    found_reg;
    logic [POS_W-1:0]        pos_reg;

    logic                    req_accept;
    logic                    is_search;
    logic                    range_ok;
    logic [HIGH_W-1:0]       span_cur;
    logic                    more;
    logic                    less;
    logic                    hit;
    logic                    slot_free;
    logic                    finish;
    logic [POS_W-1:0]        nlo;
    logic [HIGH_W-1:0]       nhi;
    logic [POS_W-1:0]        op_lo;
    logic [HIGH_W-1:0]       op_hi;
    logic [HIGH_W-1:0]       span;
    logic [POS_W-1:0]        mid;

    assign req.ready  = (state_reg == ST_IDLE);
    assign req_accept = req.valid && req.ready;
    assign is_search  = (req.payload.cmd == CMD_SEARCH);
    assign range_ok   = (req.payload.range_high > {1'b0, req.payload.range_low})
                     && (17'(req.payload.range_high) <= DEPTH_L);

    // table write on a load
    assign table_we    = req_accept && (req.payload.cmd == CMD_LOAD)
                      && (17'(req.payload.entry_index) < DEPTH_L);
    assign table_waddr = AW'(req.payload.entry_index);
    assign table_wdata = VALUE_WIDTH'(req.payload.entry_value);

    // probe result
    assign span_cur  = hi_reg - {1'b0, lo_reg};
    assign more      = (span_cur > 11'd1);
    assign less      = (key_reg < table_rdata);
    assign hit       = !bad_reg && (table_rdata == key_reg);
    assign slot_free = !out_valid_reg || rsp.ready;
    assign finish    = (state_reg == ST_PROBE) && !more && slot_free;
    assign nlo       = less ? lo_reg : mid_reg;
    assign nhi       = less ? {1'b0, mid_reg} : hi_reg;

    // shared midpoint unit: operands from the new request, the narrowed window or the held final window
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            op_lo = req.payload.range_low;
            op_hi = req.payload.range_high;
        end
        else if (more)
        begin
            op_lo = nlo;
            op_hi = nhi;
        end
        else
        begin
            op_lo = lo_reg;
            op_hi = hi_reg;
        end
    end

    assign span        = op_hi - {1'b0, op_lo};
    assign mid         = op_lo + span[HIGH_W-1:1];
    assign table_raddr = (span > 11'd1) ? AW'(mid) : AW'(op_lo);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lo_reg        <= '0;
            hi_reg        <= '0;
            mid_reg       <= '0;
            key_reg       <= '0;
            bad_reg       <= 1'b0;
            found_reg     <= 1'b0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mid_reg <= mid;
            if (out_valid_reg && rsp.ready && !finish)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_accept && is_search)
                    begin
                        key_reg <= VALUE_WIDTH'(req.payload.search_key);
                        lo_reg  <= req.payload.range_low;
                        bad_reg <= !range_ok;
                        // bad range: one-entry window, result masked
                        hi_reg  <= range_ok ? req.payload.range_high
                                            : {1'b0, req.payload.range_low} + 11'd1;
                        state_reg <= ST_PROBE;
                    end
                end
                ST_PROBE:
                begin
                    if (more)
                    begin
                        lo_reg <= nlo;
                        hi_reg <= nhi;
                    end
                    else if (slot_free)
                    begin
                        out_valid_reg <= 1'b1;
                        found_reg     <= hit;
                        pos_reg       <= hit ? lo_reg : '0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.payload.found    = found_reg;
    assign rsp.payload.position = pos_reg;

`ifndef SYNTHESIS
    a_window_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_PROBE |-> hi_reg > {1'b0, lo_reg})
        else $error("search window empty");

    a_window_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE && more) |=> (hi_reg - {1'b0, lo_reg}) < $past(span_cur))
        else $error("search window did not shrink");

    a_miss_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.payload.found) |-> rsp.payload.position == '0)
        else $error("miss with nonzero position");

    a_result_from_probe: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_PROBE)
        else $error("result without a search");

    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        table_we |-> state_reg == ST_IDLE)
        else $error("table write during search");
`endif

endmodule

// ----- rtl/core/sorted_table_binary_search_unit.sv -----
`timescale 1ns / 1ps

// Sorted-table binary search unit.
// req carries one transaction per item: cmd = load writes entry_value to
// entry_index (ignored past TABLE_DEPTH); cmd = search looks up search_key
// in the half-open range [range_low, range_high). Software keeps the table
// ascending. rsp returns one transaction per search (found, position) and
// none per load; with duplicates the last match of the run is reported.
// Loads are taken back to back. A search of n entries walks a shared
// midpoint/compare unit against the table's registered read port: one
// table read per cycle, halving the window until one entry is left, then
// one final compare; req.ready drops meanwhile and the next item can be
// taken in the cycle after the final compare. An empty range or one past
// TABLE_DEPTH answers not found without any halving step.
// rsp is a registered output: a result may wait while the next item is
// taken; if a result is still stalled when the next one is ready, the
// unit holds its final compare until rsp.ready.
// Reset (rst_n, async, active low) idles the sequencer and drops rsp.valid;
// table contents are not cleared and read undefined until loaded.
module sorted_table_binary_search_unit #(
    parameter int TABLE_DEPTH = 1024,
    parameter int VALUE_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    stbs_req_if.sink   req,
    stbs_rsp_if.source rsp
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic                          table_we;
    logic [AW-1:0]                 table_waddr;
    logic signed [VALUE_WIDTH-1:0] table_wdata;
    logic [AW-1:0]                 table_raddr;
    logic signed [VALUE_WIDTH-1:0] table_rdata;

    // sequencer with the shared midpoint/compare unit
    stbs_seq #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .table_we    (table_we),
        .table_waddr (table_waddr),
        .table_wdata (table_wdata),
        .table_raddr (table_raddr),
        .table_rdata (table_rdata)
    );

    // table storage, read data registered
    stbs_table #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (VALUE_WIDTH)
    ) u_table (
        .clk   (clk),
        .we    (table_we),
        .waddr (table_waddr),
        .wdata (table_wdata),
        .raddr (table_raddr),
        .rdata (table_rdata)
    );

endmodule

// ----- verif/sorted_table_binary_search_unit_test.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the sorted-table binary search unit.
module sorted_table_binary_search_unit_test;
    import stbs_pkg::*;

    localparam int TABLE_DEPTH   = 1024;
    localparam int RESET_CYCLES  = 4;
    localparam int LONG_STALL    = 300;   // receiver hold-off during the pressure burst
    localparam int QUIET_LIMIT   = 3000;  // cycles with no transaction on either side
    localparam int DRAIN_CYCLES  = 40;    // > one full 1024-entry search
    localparam int PHASE_BUDGET  = 75;
    localparam int MAX_PRINTED   = 40;

    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

    // Scoreboard: shadow table plus the queue of answers still owed by the block.
    class search_scoreboard;
        logic signed [WORD_W-1:0] entries [TABLE_DEPTH];
        bit                       loaded  [TABLE_DEPTH];
        stbs_rsp_t                answers [$];
        int                       mismatches;
        int                       results_seen;

        function new();
            mismatches   = 0;
            results_seen = 0;
            foreach (loaded[i]) loaded[i] = 1'b0;
        endfunction

        // Half-open binary search without equality test until one entry is left.
        function stbs_rsp_t lookup(logic signed [WORD_W-1:0] key,
                                   logic [POS_W-1:0] lo_in, logic [HIGH_W-1:0] hi_in);
            stbs_rsp_t answer;
            int        lo;
            int        hi;
            int        mid;
            answer = '0;
            lo     = int'(lo_in);
            hi     = int'(hi_in);
            if (hi > lo && hi <= TABLE_DEPTH) begin
                while (hi - lo > 1) begin
                    mid = lo + (hi - lo) / 2;
                    if (key < entries[mid])
                        hi = mid;
                    else
                        lo = mid;
                end
                if (entries[lo] == key) begin
                    answer.found    = 1'b1;
                    answer.position = lo[POS_W-1:0];
                end
            end
            return answer;
        endfunction

        function void note_request(stbs_req_t item);
            if (item.cmd == CMD_LOAD) begin
                if (int'(item.entry_index) < TABLE_DEPTH) begin
                    entries[item.entry_index] = item.entry_value;
                    loaded[item.entry_index]  = 1'b1;
                end
            end
            else begin
                answers.push_back(lookup(item.search_key, item.range_low, item.range_high));
            end
        endfunction

        task report_mismatch(string what);
            mismatches++;
            if (mismatches <= MAX_PRINTED)
                $display("[%0t] mismatch: %s", $realtime, what);
        endtask

        task check_answer(stbs_rsp_t got);
            stbs_rsp_t want;
            results_seen++;
            if (answers.size() == 0) begin
                report_mismatch($sformatf("result %0d not expected (found=%0d position=%0d)",
                                          results_seen, got.found, got.position));
                return;
            end
            want = answers.pop_front();
            if (got.found !== want.found)
                report_mismatch($sformatf("result %0d found: got %0d want %0d",
                                          results_seen, got.found, want.found));
            if (got.position !== want.position)
                report_mismatch($sformatf("result %0d position: got %0d want %0d",
                                          results_seen, got.position, want.position));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    stbs_req_if req_ch ();
    stbs_rsp_if rsp_ch ();

    sorted_table_binary_search_unit #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (WORD_W)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    search_scoreboard sb;

    int send_idle_pct;       // chance in 100 that the sender idles a cycle
    int recv_stall_pct;      // chance in 100 that the receiver drops ready
    int sent_items;
    int last_base;           // start of the most recently loaded window
    int stall_requests;      // bumped by the stimulus to ask for a long hold-off
    int stall_served;        // receiver's copy; differs from stall_requests -> start hold
    int stall_left;
    int quiet_cycles;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver: checks every accepted result, then picks next cycle's ready.
    // A long hold-off, when requested, is counted down here and overrides the
    // random stall so the block backs up into its request side.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            stall_served <= 0;
            stall_left   <= 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_answer(rsp_ch.payload);
            if (stall_served != stall_requests)
            begin
                stall_served <= stall_requests;
                stall_left   <= LONG_STALL;
                rsp_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left   <= stall_left - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Watchdog: a hang shows up as a long run with no transaction anywhere.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Fields that the command does not use get random junk on purpose.
    function automatic stbs_req_t make_load(int idx, logic signed [WORD_W-1:0] value);
        stbs_req_t item;
        item             = stbs_req_t'({$urandom, $urandom, $urandom});
        item.cmd         = CMD_LOAD;
        item.entry_index = idx[POS_W-1:0];
        item.entry_value = value;
        return item;
    endfunction

    function automatic stbs_req_t make_search(logic signed [WORD_W-1:0] key, int lo, int hi);
        stbs_req_t item;
        item            = stbs_req_t'({$urandom, $urandom, $urandom});
        item.cmd        = CMD_SEARCH;
        item.search_key = key;
        item.range_low  = lo[POS_W-1:0];
        item.range_high = hi[HIGH_W-1:0];
        return item;
    endfunction

    // Each index owns a 2^22-wide slice of the signed range, so values drawn
    // this way keep the whole table ascending no matter which windows are
    // rewritten. Index 0 can hit the most negative word, 1023 the most positive.
    function automatic logic signed [WORD_W-1:0] slice_value(int idx);
        return (idx - TABLE_DEPTH / 2) * (1 << 22) + int'($urandom_range((1 << 22) - 1));
    endfunction

    // Offer one transaction, idling first at random; valid stays high across
    // back-to-back transactions.
    task automatic push_request(input stbs_req_t item);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= item;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_request(item);
        sent_items++;
    endtask

    // Fill a contiguous window in ascending order; about a third of the
    // entries repeat their left neighbor to build runs of duplicates.
    task automatic load_window();
        int                       base;
        int                       size;
        logic signed [WORD_W-1:0] value;
        size = ($urandom_range(11) == 0) ? $urandom_range(160, 48) : $urandom_range(24, 1);
        base = $urandom_range(TABLE_DEPTH - size);
        for (int idx = base; idx < base + size; idx++)
        begin
            if (idx > 0 && sb.loaded[idx - 1] && $urandom_range(2) == 0)
                value = sb.entries[idx - 1];
            else
                value = slice_value(idx);
            push_request(make_load(idx, value));
        end
        last_base = base;
    endtask

    // Search inside a run of loaded entries only, so no read ever touches an
    // entry that was never written. Keys are hits half the time, else near misses or random.
    task automatic search_loaded_run();
        int                       seed_idx;
        int                       run_lo;
        int                       run_hi;
        int                       lo;
        int                       hi;
        int                       pick;
        int                       probe;
        logic signed [WORD_W-1:0] key;
        seed_idx = last_base;
        repeat (8)
        begin
            probe = $urandom_range(TABLE_DEPTH - 1);
            if (sb.loaded[probe])
                seed_idx = probe;
        end
        run_lo = seed_idx;
        while (run_lo > 0 && sb.loaded[run_lo - 1])
            run_lo--;
        run_hi = seed_idx + 1;
        while (run_hi < TABLE_DEPTH && sb.loaded[run_hi])
            run_hi++;
        if ($urandom_range(1) == 0)
        begin
            lo = run_lo;
            hi = run_hi;
        end
        else
        begin
            lo = $urandom_range(seed_idx, run_lo);
            hi = $urandom_range(run_hi, seed_idx + 1);
        end
        pick = $urandom_range(hi - 1, lo);
        case ($urandom_range(3))
            0, 1:    key = sb.entries[pick];
            2:       key = ($urandom_range(1) == 0) ? sb.entries[pick] + 1
                                                    : sb.entries[pick] - 1;
            default: key = $urandom;
        endcase
        push_request(make_search(key, lo, hi));
    endtask

    // Noise: empty or reversed ranges, ranges past the table end, and the odd
    // load of an arbitrary value that breaks the ordering locally.
    task automatic push_noise();
        int lo;
        int hi;
        lo = $urandom_range(TABLE_DEPTH - 1);
        case ($urandom_range(2))
            0:
            begin
                hi = $urandom_range(lo, 0);
                push_request(make_search($urandom, lo, hi));
            end
            1:
            begin
                hi = $urandom_range(2 * TABLE_DEPTH - 1, TABLE_DEPTH + 1);
                push_request(make_search($urandom, lo, hi));
            end
            default:
                push_request(make_load(lo, $urandom));
        endcase
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int budget);
        int stop_at;
        send_idle_pct   = idle_pct;
        recv_stall_pct <= stall_pct;
        stop_at         = sent_items + budget;
        while (sent_items < stop_at)
        begin
            if ($urandom_range(99) < 15)
                push_noise();
            else
            begin
                load_window();
                repeat ($urandom_range(10, 2))
                    search_loaded_run();
            end
        end
    endtask

    initial
    begin
        sb              = new();
        send_idle_pct   = 0;
        sent_items      = 0;
        last_base       = 0;
        rst_n          <= 1'b0;
        recv_stall_pct <= 0;
        stall_requests <= 0;
        req_ch.valid   <= 1'b0;
        req_ch.payload <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: both ends of the table, extreme words, a duplicate run.
        push_request(make_load(0, WORD_MIN));
        push_request(make_load(1, -5));
        push_request(make_load(2, 7));
        push_request(make_load(3, 7));
        push_request(make_load(4, 7));
        push_request(make_load(5, 1000));
        push_request(make_load(1021, 100));
        push_request(make_load(1022, 100));
        push_request(make_load(TABLE_DEPTH - 1, WORD_MAX));

        push_request(make_search(WORD_MIN, 0, 6));                        // hit at the bottom
        push_request(make_search(7, 0, 6));                               // last of the run
        push_request(make_search(8, 0, 6));                               // miss between values
        push_request(make_search(1000, 0, 6));                            // hit at range top
        push_request(make_search(WORD_MIN, 1, 6));                        // key below range
        push_request(make_search(-6, 0, 2));                              // miss, small range
        push_request(make_search(7, 3, 4));                               // single entry
        push_request(make_search(WORD_MAX, 1021, TABLE_DEPTH));           // hit at the top
        push_request(make_search(100, 1021, TABLE_DEPTH));                // duplicate at top
        push_request(make_search(100, TABLE_DEPTH - 1, TABLE_DEPTH));     // last entry, miss
        push_request(make_search(7, 5, 5));                               // empty range
        push_request(make_search(7, TABLE_DEPTH - 1, 0));                 // reversed range
        push_request(make_search(7, 0, 2 * TABLE_DEPTH - 1));             // far past the end
        push_request(make_search(100, 1021, TABLE_DEPTH + 1));            // just past the end

        // Random phases: no idling, then sender gaps, receiver stalls, both.
        run_phase(0, 0, PHASE_BUDGET);

        // Pressure: receiver holds off while the sender keeps offering searches,
        // so the result register fills and the request side stalls.
        stall_requests <= stall_requests + 1;
        repeat (10)
            search_loaded_run();

        run_phase(74, 0, PHASE_BUDGET);
        run_phase(0, 74, PHASE_BUDGET);
        run_phase(14, 14, PHASE_BUDGET);

        req_ch.valid <= 1'b0;
        while (sb.answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
